@@ src/pfb_pkg.sv @@
// Shared types, codes and constants of the page framebuffer pixel engine.
package pfb_pkg;

    localparam int COLUMNS_DEF = 128;
    localparam int PAGES_DEF   = 8;

    localparam int KIND_W  = 4;
    localparam int BYTE_W  = 8;
    localparam int COL_W   = 7;
    localparam int ROW_W   = 6;
    localparam int PAGE_W  = 3;
    localparam int WKIND_W = 2;

    localparam int QUEUE_DEPTH = 2;
    localparam int DIRECT_MAX  = 4;
    localparam int DCOUNT_W    = 3;

    localparam logic [7:0] CMD_PAGE   = 8'hB0;
    localparam logic [7:0] CMD_COL_HI = 8'h10;
    localparam logic [7:0] CMD_COL_LO = 8'h00;

    typedef enum logic [KIND_W-1:0] {
        K_WRITE     = 4'd0,
        K_SET_PAGE  = 4'd1,
        K_SET_COL   = 4'd2,
        K_PIX_SET   = 4'd3,
        K_PIX_CLR   = 4'd4,
        K_PIX_INV   = 4'd5,
        K_PIX_READ  = 4'd6,
        K_BYTE_READ = 4'd7,
        K_REFRESH   = 4'd8,
        K_CLEAR     = 4'd9
    } kind_t;

    typedef enum logic [WKIND_W-1:0] {
        WK_CMD  = 2'd0,
        WK_DATA = 2'd1,
        WK_READ = 2'd2
    } word_kind_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_WRITE,
        OP_PAGE,
        OP_COL,
        OP_PIX_SET,
        OP_PIX_CLR,
        OP_PIX_INV,
        OP_PIX_READ,
        OP_BYTE_READ,
        OP_REFRESH,
        OP_CLEAR,
        OP_DIRECT
    } op_t;

    typedef struct packed {
        word_kind_t        kind;
        logic [BYTE_W-1:0] value;
        logic              frame_end;
    } word_t;

    // one classified item as it travels from front to back
    typedef struct packed {
        op_t                          op;
        logic [BYTE_W-1:0]            data;
        logic [COL_W-1:0]             col;
        logic [PAGE_W-1:0]            page;
        logic [BYTE_W-1:0]            mask;
        logic [DCOUNT_W-1:0]          count;
        word_t [DIRECT_MAX-1:0]       words;
    } cmd_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_FETCH,
        B_CLEAR
    } bstate_t;

    typedef enum logic [1:0] {
        RH_LOW,
        RH_HIGH,
        RH_BODY
    } rhead_t;

endpackage

@@ src/pfb_in_if.sv @@
// Input item channel: valid/ready handshake with the item fields.
interface pfb_in_if;
    logic                          valid;
    logic                          ready;
    logic [pfb_pkg::KIND_W-1:0]    kind;
    logic [pfb_pkg::BYTE_W-1:0]    data_byte;
    logic [pfb_pkg::COL_W-1:0]     column;
    logic [pfb_pkg::ROW_W-1:0]     row;
    logic [pfb_pkg::PAGE_W-1:0]    page;

    modport source (output valid, kind, data_byte, column, row, page, input ready);
    modport sink   (input valid, kind, data_byte, column, row, page, output ready);
endinterface

@@ src/pfb_out_if.sv @@
// Result word channel: valid/ready handshake with the word fields.
interface pfb_out_if;
    logic                          valid;
    logic                          ready;
    logic [pfb_pkg::WKIND_W-1:0]   word_kind;
    logic [pfb_pkg::BYTE_W-1:0]    value;
    logic                          frame_end;

    modport source (output valid, word_kind, value, frame_end, input ready);
    modport sink   (input valid, word_kind, value, frame_end, output ready);
endinterface

@@ src/pfb_front.sv @@
// Front end: mode register, item transfer and classification into commands.
module pfb_front #(
    parameter int COLUMNS = pfb_pkg::COLUMNS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    pfb_in_if.sink         items,
    input  logic           cfg_we,
    input  logic           cfg_wdata,
    input  logic           q_full,
    input  logic           clearing,
    output logic           push,
    output pfb_pkg::cmd_t  cmd
);
    import pfb_pkg::*;

    logic mode_reg;

    // column modulo COLUMNS by restoring subtraction, quotient is below 16
    function automatic logic [COL_W-1:0] col_mod(input logic [COL_W-1:0] c);
        logic [COL_W:0] v;
        v = {1'b0, c};
        for (int k = 3; k >= 0; k--) begin
            if (int'(v) >= (COLUMNS << k)) begin
                v = v - (COL_W+1)'(COLUMNS << k);
            end
        end
        return v[COL_W-1:0];
    endfunction

    function automatic word_t mk(input word_kind_t k, input logic [BYTE_W-1:0] v,
                                 input logic e);
        word_t w;
        w.kind      = k;
        w.value     = v;
        w.frame_end = e;
        return w;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            mode_reg <= cfg_wdata;
        end
    end

    assign items.ready = !q_full && !clearing;
    assign push        = items.valid && items.ready;

    always_comb
    begin
        cmd       = '0;
        cmd.op    = OP_NOP;
        cmd.data  = items.data_byte;
        cmd.col   = col_mod(items.column);
        cmd.page  = items.page;
        cmd.mask  = 8'b1 << items.row[2:0];
        cmd.count = '0;
        for (int i = 0; i < DIRECT_MAX; i++)
        begin
            cmd.words[i] = mk(WK_CMD, '0, 1'b0);
        end
        if (mode_reg)
        begin
            case (kind_t'(items.kind))
                K_WRITE:     cmd.op = OP_WRITE;
                K_SET_PAGE:  cmd.op = OP_PAGE;
                K_SET_COL:   cmd.op = OP_COL;
                K_PIX_SET:
                begin
                    cmd.op   = OP_PIX_SET;
                    cmd.page = items.row[5:3];
                end
                K_PIX_CLR:
                begin
                    cmd.op   = OP_PIX_CLR;
                    cmd.page = items.row[5:3];
                end
                K_PIX_INV:
                begin
                    cmd.op   = OP_PIX_INV;
                    cmd.page = items.row[5:3];
                end
                K_PIX_READ:
                begin
                    cmd.op   = OP_PIX_READ;
                    cmd.page = items.row[5:3];
                end
                K_BYTE_READ: cmd.op = OP_BYTE_READ;
                K_REFRESH:   cmd.op = OP_REFRESH;
                K_CLEAR:     cmd.op = OP_CLEAR;
                default:     cmd.op = OP_NOP;
            endcase
        end
        else
        begin
            cmd.op = OP_DIRECT;
            case (kind_t'(items.kind))
                K_WRITE:
                begin
                    cmd.words[0] = mk(WK_DATA, items.data_byte, 1'b1);
                    cmd.count    = 3'd1;
                end
                K_SET_PAGE:
                begin
                    cmd.words[0] = mk(WK_CMD, CMD_PAGE + {5'd0, items.page}, 1'b1);
                    cmd.count    = 3'd1;
                end
                K_SET_COL:
                begin
                    cmd.words[0] = mk(WK_CMD, CMD_COL_LO | {4'd0, items.column[3:0]}, 1'b0);
                    cmd.words[1] = mk(WK_CMD, CMD_COL_HI | {5'd0, items.column[6:4]}, 1'b1);
                    cmd.count    = 3'd2;
                end
                K_PIX_SET, K_PIX_CLR, K_PIX_INV:
                begin
                    cmd.words[0] = mk(WK_CMD, CMD_COL_LO | {4'd0, items.column[3:0]}, 1'b0);
                    cmd.words[1] = mk(WK_CMD, CMD_COL_HI | {5'd0, items.column[6:4]}, 1'b0);
                    cmd.words[2] = mk(WK_CMD, CMD_PAGE + {5'd0, items.row[5:3]}, 1'b0);
                    cmd.words[3] = mk(WK_DATA,
                                      (kind_t'(items.kind) == K_PIX_CLR) ? 8'd0 : cmd.mask,
                                      1'b1);
                    cmd.count    = 3'd4;
                end
                K_PIX_READ:
                begin
                    cmd.words[0] = mk(WK_CMD, CMD_COL_LO | {4'd0, items.column[3:0]}, 1'b0);
                    cmd.words[1] = mk(WK_CMD, CMD_COL_HI | {5'd0, items.column[6:4]}, 1'b0);
                    cmd.words[2] = mk(WK_CMD, CMD_PAGE + {5'd0, items.row[5:3]}, 1'b1);
                    cmd.words[3] = mk(WK_READ, 8'd0, 1'b0);
                    cmd.count    = 3'd4;
                end
                K_BYTE_READ:
                begin
                    cmd.words[0] = mk(WK_READ, 8'd0, 1'b0);
                    cmd.count    = 3'd1;
                end
                K_REFRESH:
                begin
                    cmd.words[0] = mk(WK_CMD, CMD_COL_LO, 1'b0);
                    cmd.words[1] = mk(WK_CMD, CMD_COL_HI, 1'b1);
                    cmd.count    = 3'd2;
                end
                default:     cmd.op = OP_NOP;
            endcase
        end
    end

endmodule

@@ src/pfb_queue.sv @@
// Short command queue between front and back.
module pfb_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  pfb_pkg::cmd_t  push_cmd,
    output logic           full,
    output logic           head_valid,
    output pfb_pkg::cmd_t  head_cmd,
    input  logic           pop
);
    import pfb_pkg::*;

    localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    cmd_t             slot_reg [QUEUE_DEPTH];
    logic [QAW-1:0]   wr_ptr_reg;
    logic [QAW-1:0]   wr_ptr_next;
    logic [QAW-1:0]   rd_ptr_reg;
    logic [QAW-1:0]   rd_ptr_next;
    logic [QCW-1:0]   count_reg;
    logic [QCW-1:0]   count_next;
    logic             do_push;
    logic             do_pop;

    assign full       = (count_reg == QCW'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + QCW'(do_push) - QCW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ src/pfb_back.sv @@
// Back end: frame store, cursor, refresh sequencer and result word register.
module pfb_back #(
    parameter int COLUMNS = pfb_pkg::COLUMNS_DEF,
    parameter int PAGES   = pfb_pkg::PAGES_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  pfb_pkg::cmd_t  q_head,
    output logic           q_pop,
    output logic           clearing,
    pfb_out_if.source      words
);
    import pfb_pkg::*;

    localparam int STORE = COLUMNS * PAGES;
    localparam int AW    = $clog2(STORE);
    localparam int CW    = $clog2(COLUMNS);
    localparam int PMAX  = (PAGES > 7) ? PAGES : 7;
    localparam int PW    = $clog2(PMAX + 1);
    localparam int RPW   = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int RCW   = $clog2(COLUMNS + 1);

    logic [BYTE_W-1:0] mem [STORE];
    logic [BYTE_W-1:0] rdata_reg;

    bstate_t           state_reg, state_next;
    logic [PW-1:0]     cpage_reg, cpage_next;
    logic [CW-1:0]     ccol_reg, ccol_next;
    rhead_t            rhead_reg, rhead_next;
    logic [RPW-1:0]    rpage_reg, rpage_next;
    logic [RCW-1:0]    rcol_reg, rcol_next;
    logic [AW-1:0]     clr_reg, clr_next;
    logic [1:0]        widx_reg, widx_next;
    logic              out_valid_reg, out_valid_next;
    word_t             out_word_reg, out_word_next;

    logic              mem_we;
    logic              mem_re;
    logic [AW-1:0]     mem_addr;
    logic [BYTE_W-1:0] mem_wdata;
    logic              emit;
    word_t             emit_word;
    logic              rf_adv;

    logic              can_emit;
    logic              in_range;
    logic              n_in_range;
    logic [PW-1:0]     n_page;
    logic [CW-1:0]     n_col;
    logic              last_col;
    logic [CW-1:0]     adv_col;
    logic [PW-1:0]     adv_page;
    logic              rf_data;
    logic              rf_last;
    logic [BYTE_W-1:0] rf_cmd;
    logic [BYTE_W-1:0] fetch_b;
    logic              direct_last;

    function automatic logic [AW-1:0] store_addr(input logic [PW-1:0] p,
                                                 input logic [CW-1:0] c);
        return AW'(int'(p) * COLUMNS + int'(c));
    endfunction

    assign can_emit    = !out_valid_reg || words.ready;
    assign in_range    = (cpage_reg < PW'(PAGES));
    assign n_page      = PW'(q_head.page);
    assign n_col       = CW'(q_head.col);
    assign n_in_range  = (n_page < PW'(PAGES));
    assign last_col    = (ccol_reg == CW'(COLUMNS - 1));
    assign adv_col     = last_col ? '0 : ccol_reg + 1'b1;
    assign adv_page    = last_col ? cpage_reg + 1'b1 : cpage_reg;
    assign rf_data     = (rhead_reg == RH_BODY) && (rcol_reg != '0);
    assign rf_last     = (rhead_reg == RH_BODY) && (rpage_reg == RPW'(PAGES - 1))
                         && (rcol_reg == RCW'(COLUMNS));
    assign fetch_b     = in_range ? rdata_reg : '0;
    assign direct_last = (DCOUNT_W'(widx_reg) + 1'b1) == q_head.count;
    assign clearing    = (state_reg == B_CLEAR);

    always_comb
    begin
        case (rhead_reg)
            RH_LOW:  rf_cmd = CMD_COL_LO;
            RH_HIGH: rf_cmd = CMD_COL_HI;
            default: rf_cmd = CMD_PAGE + BYTE_W'(rpage_reg);
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_head.op)
                        OP_PIX_SET, OP_PIX_CLR, OP_PIX_INV, OP_PIX_READ, OP_BYTE_READ:
                            state_next = B_FETCH;
                        OP_REFRESH:
                            state_next = rf_data ? B_FETCH : B_IDLE;
                        OP_CLEAR:
                            state_next = B_CLEAR;
                        default:
                            state_next = B_IDLE;
                    endcase
                end
            end
            B_FETCH:
            begin
                case (q_head.op)
                    OP_PIX_SET, OP_PIX_CLR, OP_PIX_INV:
                        state_next = B_IDLE;
                    default:
                        state_next = can_emit ? B_IDLE : B_FETCH;
                endcase
            end
            B_CLEAR:
            begin
                if (clr_reg == AW'(STORE - 1))
                begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        q_pop      = 1'b0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_addr   = store_addr(cpage_reg, ccol_reg);
        mem_wdata  = q_head.data;
        emit       = 1'b0;
        emit_word  = q_head.words[0];
        rf_adv     = 1'b0;
        cpage_next = cpage_reg;
        ccol_next  = ccol_reg;
        clr_next   = clr_reg;
        widx_next  = widx_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_head.op)
                        OP_WRITE:
                        begin
                            q_pop = 1'b1;
                            if (in_range)
                            begin
                                mem_we     = 1'b1;
                                cpage_next = adv_page;
                                ccol_next  = adv_col;
                            end
                        end
                        OP_PAGE:
                        begin
                            q_pop      = 1'b1;
                            cpage_next = n_page;
                        end
                        OP_COL:
                        begin
                            q_pop     = 1'b1;
                            ccol_next = n_col;
                        end
                        OP_PIX_SET, OP_PIX_CLR, OP_PIX_INV, OP_PIX_READ:
                        begin
                            cpage_next = n_page;
                            ccol_next  = n_col;
                            mem_re     = n_in_range;
                            mem_addr   = store_addr(n_page, n_col);
                        end
                        OP_BYTE_READ:
                        begin
                            mem_re = in_range;
                        end
                        OP_REFRESH:
                        begin
                            if (rf_data)
                            begin
                                mem_re   = 1'b1;
                                mem_addr = AW'(int'(rpage_reg) * COLUMNS + int'(rcol_reg) - 1);
                            end
                            else if (can_emit)
                            begin
                                emit      = 1'b1;
                                emit_word = '{kind: WK_CMD, value: rf_cmd, frame_end: rf_last};
                                rf_adv    = 1'b1;
                                q_pop     = 1'b1;
                            end
                        end
                        OP_CLEAR:
                        begin
                            q_pop      = 1'b1;
                            cpage_next = PW'(PAGES);
                            ccol_next  = '0;
                            clr_next   = '0;
                        end
                        OP_DIRECT:
                        begin
                            if (can_emit)
                            begin
                                emit      = 1'b1;
                                emit_word = q_head.words[widx_reg];
                                if (direct_last)
                                begin
                                    q_pop     = 1'b1;
                                    widx_next = '0;
                                end
                                else
                                begin
                                    widx_next = widx_reg + 1'b1;
                                end
                            end
                        end
                        default: q_pop = 1'b1;
                    endcase
                end
            end
            B_FETCH:
            begin
                case (q_head.op)
                    OP_PIX_SET, OP_PIX_CLR, OP_PIX_INV:
                    begin
                        q_pop = 1'b1;
                        case (q_head.op)
                            OP_PIX_SET: mem_wdata = fetch_b | q_head.mask;
                            OP_PIX_CLR: mem_wdata = fetch_b & ~q_head.mask;
                            default:    mem_wdata = fetch_b ^ q_head.mask;
                        endcase
                        if (in_range)
                        begin
                            mem_we     = 1'b1;
                            cpage_next = adv_page;
                            ccol_next  = adv_col;
                        end
                    end
                    OP_PIX_READ:
                    begin
                        if (can_emit)
                        begin
                            emit      = 1'b1;
                            emit_word = '{kind: WK_READ,
                                          value: {7'd0, |(fetch_b & q_head.mask)},
                                          frame_end: 1'b0};
                            q_pop     = 1'b1;
                        end
                    end
                    OP_REFRESH:
                    begin
                        if (can_emit)
                        begin
                            emit      = 1'b1;
                            emit_word = '{kind: WK_DATA, value: rdata_reg, frame_end: rf_last};
                            rf_adv    = 1'b1;
                            q_pop     = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (can_emit)
                        begin
                            emit      = 1'b1;
                            emit_word = '{kind: WK_READ, value: fetch_b, frame_end: 1'b0};
                            q_pop     = 1'b1;
                        end
                    end
                endcase
            end
            B_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_addr  = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + 1'b1;
            end
            default: q_pop = 1'b0;
        endcase
    end

    // refresh frame position
    always_comb
    begin
        rhead_next = rhead_reg;
        rpage_next = rpage_reg;
        rcol_next  = rcol_reg;
        if (rf_adv)
        begin
            case (rhead_reg)
                RH_LOW:  rhead_next = RH_HIGH;
                RH_HIGH:
                begin
                    rhead_next = RH_BODY;
                    rpage_next = '0;
                    rcol_next  = '0;
                end
                default:
                begin
                    if (rf_last)
                    begin
                        rhead_next = RH_LOW;
                        rpage_next = '0;
                        rcol_next  = '0;
                    end
                    else if (rcol_reg == RCW'(COLUMNS))
                    begin
                        rpage_next = rpage_reg + 1'b1;
                        rcol_next  = '0;
                    end
                    else
                    begin
                        rcol_next = rcol_reg + 1'b1;
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_word_next  = emit_word;
        end
        else
        begin
            out_valid_next = out_valid_reg && !words.ready;
            out_word_next  = out_word_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            cpage_reg     <= '0;
            ccol_reg      <= '0;
            rhead_reg     <= RH_LOW;
            rpage_reg     <= '0;
            rcol_reg      <= '0;
            clr_reg       <= '0;
            widx_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cpage_reg     <= cpage_next;
            ccol_reg      <= ccol_next;
            rhead_reg     <= rhead_next;
            rpage_reg     <= rpage_next;
            rcol_reg      <= rcol_next;
            clr_reg       <= clr_next;
            widx_reg      <= widx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_addr];
        end
    end

    assign words.valid     = out_valid_reg;
    assign words.word_kind = out_word_reg.kind;
    assign words.value     = out_word_reg.value;
    assign words.frame_end = out_word_reg.frame_end;

endmodule

@@ src/page_framebuffer_pixel_engine.sv @@
// Top level of the page framebuffer pixel engine: front, command queue and back.
// Buffered write, set page and set column are handled in the back's idle state; pixel
// and read ops do a single-port store read, then a write or an answer; refresh emits
// a command word directly and a data word after a store read; direct mode emits one
// word per cycle while the output is not stalled; clear zeroes the whole store.
// After reset the store is cleared with the input not ready.
module page_framebuffer_pixel_engine #(
    parameter int COLUMNS = pfb_pkg::COLUMNS_DEF,
    parameter int PAGES   = pfb_pkg::PAGES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    pfb_in_if.sink     items,
    pfb_out_if.source  words,
    input  logic       cfg_we,
    input  logic       cfg_wdata
);
    import pfb_pkg::*;

    cmd_t front_cmd;
    cmd_t head_cmd;
    logic push;
    logic q_full;
    logic q_valid;
    logic q_pop;
    logic clearing;

    pfb_front #(
        .COLUMNS (COLUMNS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .items     (items),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_full    (q_full),
        .clearing  (clearing),
        .push      (push),
        .cmd       (front_cmd)
    );

    pfb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (front_cmd),
        .full       (q_full),
        .head_valid (q_valid),
        .head_cmd   (head_cmd),
        .pop        (q_pop)
    );

    pfb_back #(
        .COLUMNS (COLUMNS),
        .PAGES   (PAGES)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_head   (head_cmd),
        .q_pop    (q_pop),
        .clearing (clearing),
        .words    (words)
    );

endmodule

@@ src/pfb_checker.sv @@
// Port-level checks of the pixel engine and their bind to the top level.
module pfb_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] out_kind,
    input logic [7:0] out_value,
    input logic       out_end
);
    import pfb_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_kind)
                                    && $stable(out_value) && $stable(out_end))
        else $error("result word changed while stalled");

    a_read_no_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind == WK_READ |-> !out_end)
        else $error("read answer flagged as frame end");

    a_init_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !in_ready)
        else $error("input ready during store clear after reset");

    a_init_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !out_valid && !(in_valid && in_ready))
        else $error("activity right after reset");

endmodule

bind page_framebuffer_pixel_engine pfb_checker u_pfb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (items.valid),
    .in_ready  (items.ready),
    .out_valid (words.valid),
    .out_ready (words.ready),
    .out_kind  (words.word_kind),
    .out_value (words.value),
    .out_end   (words.frame_end)
);

@@ dv/tb_page_framebuffer_pixel_engine.sv @@
// Self-checking testbench for the page framebuffer pixel engine in buffered and direct modes.
module tb_page_framebuffer_pixel_engine;
    import pfb_pkg::*;

    localparam int COLS          = COLUMNS_DEF;
    localparam int PGS           = PAGES_DEF;
    localparam int STORE_BYTES   = COLS * PGS;
    localparam int FRAME_LEN     = 2 + PGS * (COLS + 1);
    localparam int SETTLE_CYCLES = 2 * STORE_BYTES + 64;
    localparam int TAIL_CYCLES   = 40;
    localparam longint CYCLE_LIMIT = 1_500_000;

    localparam logic [KIND_W-1:0] KIND_UNUSED_LO = 4'd10;
    localparam logic [KIND_W-1:0] KIND_UNUSED_HI = 4'd15;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] data;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [PAGE_W-1:0] pg;
    } item_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    pfb_in_if  items_ch ();
    pfb_out_if words_ch ();

    page_framebuffer_pixel_engine dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .items     (items_ch),
        .words     (words_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // predicted block state
    logic [BYTE_W-1:0] pix_store [STORE_BYTES];
    int unsigned       pix_cursor;
    int unsigned       refresh_pos;
    bit                buffered_on;

    word_t       pending_words [$];
    int unsigned errors;
    int unsigned items_sent;
    int unsigned words_checked;
    bit          calm;
    longint unsigned cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(99);
        if (calm || r < 50)
            return 0;
        else if (r < 88)
            return $urandom_range(3, 1);
        else if (r < 97)
            return $urandom_range(12, 4);
        else
            return $urandom_range(60, 20);
    endfunction

    function automatic item_t mk(logic [KIND_W-1:0] k, logic [BYTE_W-1:0] d,
                                 logic [COL_W-1:0] c, logic [ROW_W-1:0] r,
                                 logic [PAGE_W-1:0] p);
        item_t it;
        it.kind = k;
        it.data = d;
        it.col  = c;
        it.row  = r;
        it.pg   = p;
        return it;
    endfunction

    function automatic item_t any_item(logic [KIND_W-1:0] k);
        logic [31:0] rnd;
        rnd = $urandom;
        return mk(k, rnd[7:0], rnd[14:8], rnd[20:15], rnd[23:21]);
    endfunction

    function automatic logic [KIND_W-1:0] pick_kind(logic [KIND_W-1:0] lo,
                                                    logic [KIND_W-1:0] hi);
        return KIND_W'($urandom_range(hi, lo));
    endfunction

    function automatic void push_word(word_kind_t k, logic [BYTE_W-1:0] v, logic e);
        word_t w;
        w.kind      = k;
        w.value     = v;
        w.frame_end = e;
        pending_words.push_back(w);
    endfunction

    function automatic logic [BYTE_W-1:0] byte_at_cursor();
        if (pix_cursor >= STORE_BYTES)
            return '0;
        return pix_store[pix_cursor];
    endfunction

    function automatic void write_at_cursor(logic [BYTE_W-1:0] b);
        if (pix_cursor < STORE_BYTES)
        begin
            pix_store[pix_cursor] = b;
            pix_cursor++;
        end
    endfunction

    function automatic void push_col_cmds(logic [COL_W-1:0] col, logic e);
        push_word(WK_CMD, CMD_COL_LO | {4'd0, col[3:0]}, 1'b0);
        push_word(WK_CMD, CMD_COL_HI | {5'd0, col[6:4]}, e);
    endfunction

    function automatic void predict_refresh_word();
        int unsigned p;
        int unsigned q;
        int unsigned fp;
        int unsigned r;
        logic        last;
        p = refresh_pos;
        if (p >= FRAME_LEN)
            p = 0;
        last = (p == FRAME_LEN - 1);
        if (p == 0)
            push_word(WK_CMD, CMD_COL_LO, last);
        else if (p == 1)
            push_word(WK_CMD, CMD_COL_HI, last);
        else
        begin
            q  = p - 2;
            fp = q / (COLS + 1);
            r  = q % (COLS + 1);
            if (r == 0)
                push_word(WK_CMD, CMD_PAGE + BYTE_W'(fp), last);
            else
                push_word(WK_DATA, pix_store[(fp * COLS + r - 1) % STORE_BYTES], last);
        end
        refresh_pos = last ? 0 : p + 1;
    endfunction

    function automatic void predict_item(item_t it);
        logic [BYTE_W-1:0] mask;
        logic [BYTE_W-1:0] b;
        mask = 8'd1 << it.row[2:0];
        if (buffered_on)
        begin
            case (it.kind)
                K_WRITE:     write_at_cursor(it.data);
                K_SET_PAGE:  pix_cursor = pix_cursor % COLS + int'(it.pg) * COLS;
                K_SET_COL:   pix_cursor = pix_cursor - pix_cursor % COLS + int'(it.col);
                K_PIX_SET, K_PIX_CLR, K_PIX_INV, K_PIX_READ:
                begin
                    pix_cursor = int'(it.col) + int'(it.row[5:3]) * COLS;
                    b = byte_at_cursor();
                    case (it.kind)
                        K_PIX_SET: write_at_cursor(b | mask);
                        K_PIX_CLR: write_at_cursor(b & ~mask);
                        K_PIX_INV: write_at_cursor(b ^ mask);
                        default:   push_word(WK_READ, ((b & mask) != 0) ? 8'd1 : 8'd0, 1'b0);
                    endcase
                end
                K_BYTE_READ: push_word(WK_READ, byte_at_cursor(), 1'b0);
                K_REFRESH:   predict_refresh_word();
                K_CLEAR:
                begin
                    foreach (pix_store[i])
                        pix_store[i] = '0;
                    pix_cursor = STORE_BYTES;
                end
                default: ;
            endcase
        end
        else
        begin
            case (it.kind)
                K_WRITE:    push_word(WK_DATA, it.data, 1'b1);
                K_SET_PAGE: push_word(WK_CMD, CMD_PAGE + {5'd0, it.pg}, 1'b1);
                K_SET_COL:  push_col_cmds(it.col, 1'b1);
                K_PIX_SET, K_PIX_CLR, K_PIX_INV, K_PIX_READ:
                begin
                    push_col_cmds(it.col, 1'b0);
                    push_word(WK_CMD, CMD_PAGE + {5'd0, it.row[5:3]}, it.kind == K_PIX_READ);
                    if (it.kind == K_PIX_READ)
                        push_word(WK_READ, 8'd0, 1'b0);
                    else
                        push_word(WK_DATA, (it.kind == K_PIX_CLR) ? 8'd0 : mask, 1'b1);
                end
                K_BYTE_READ: push_word(WK_READ, 8'd0, 1'b0);
                K_REFRESH:   push_col_cmds('0, 1'b1);
                default: ;
            endcase
        end
    endfunction

    // one input transfer; called at a rising edge, returns at the accepting edge
    task automatic send_item(item_t it);
        int unsigned gap;
        gap = idle_len();
        if (gap != 0)
        begin
            items_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        items_ch.valid     <= 1'b1;
        items_ch.kind      <= it.kind;
        items_ch.data_byte <= it.data;
        items_ch.column    <= it.col;
        items_ch.row       <= it.row;
        items_ch.page      <= it.pg;
        do
            @(posedge clk);
        while (items_ch.ready !== 1'b1);
        predict_item(it);
        items_sent++;
    endtask

    // no config write until all words are out and two queued clears could have finished
    task automatic drain();
        items_ch.valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_mode(bit m);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we    <= 1'b0;
        buffered_on = m;
    endtask

    task automatic test_buffered_directed();
        send_item(mk(K_WRITE, 8'h00, 7'h7F, 6'h3F, 3'h7));
        send_item(mk(K_WRITE, 8'hFF, 7'h00, 6'h00, 3'h0));
        send_item(mk(K_WRITE, 8'hA5, 7'h55, 6'h2A, 3'h5));
        // last byte of the store, then a write past the end
        send_item(mk(K_SET_PAGE, 8'h00, 7'h00, 6'h00, 3'h7));
        send_item(mk(K_SET_COL, 8'h00, 7'h7F, 6'h00, 3'h0));
        send_item(mk(K_WRITE, 8'h81, 7'h00, 6'h00, 3'h0));
        send_item(mk(K_WRITE, 8'h3C, 7'h00, 6'h00, 3'h0));
        send_item(mk(K_BYTE_READ, 8'hFF, 7'h7F, 6'h3F, 3'h7));
        send_item(mk(K_SET_COL, 8'h00, 7'h00, 6'h00, 3'h0));
        send_item(mk(K_SET_PAGE, 8'h00, 7'h00, 6'h00, 3'h0));
        send_item(mk(K_SET_COL, 8'h00, 7'h01, 6'h00, 3'h0));
        send_item(mk(K_BYTE_READ, 8'h00, 7'h00, 6'h00, 3'h0));
        send_item(mk(K_PIX_SET, 8'h00, 7'h7F, 6'h3F, 3'h0));
        send_item(mk(K_PIX_CLR, 8'hFF, 7'h00, 6'h00, 3'h7));
        send_item(mk(K_PIX_INV, 8'h00, 7'h05, 6'h09, 3'h0));
        send_item(mk(K_PIX_READ, 8'h00, 7'h05, 6'h09, 3'h0));
        send_item(mk(K_PIX_READ, 8'h00, 7'h00, 6'h00, 3'h0));
        send_item(mk(K_REFRESH, 8'h00, 7'h00, 6'h00, 3'h0));
        send_item(mk(KIND_UNUSED_HI, 8'hFF, 7'h7F, 6'h3F, 3'h7));
        send_item(mk(K_CLEAR, 8'h00, 7'h00, 6'h00, 3'h0));
        send_item(mk(K_WRITE, 8'h5A, 7'h00, 6'h00, 3'h0));
        send_item(mk(K_BYTE_READ, 8'h00, 7'h00, 6'h00, 3'h0));
    endtask

    task automatic test_direct_directed();
        send_item(mk(K_WRITE, 8'hFF, 7'h00, 6'h00, 3'h0));
        send_item(mk(K_SET_PAGE, 8'h00, 7'h00, 6'h00, 3'h7));
        send_item(mk(K_SET_COL, 8'h00, 7'h7F, 6'h00, 3'h0));
        send_item(mk(K_PIX_SET, 8'h00, 7'h7F, 6'h3F, 3'h0));
        send_item(mk(K_PIX_CLR, 8'h00, 7'h00, 6'h00, 3'h0));
        send_item(mk(K_PIX_INV, 8'h00, 7'h40, 6'h07, 3'h0));
        send_item(mk(K_PIX_READ, 8'h00, 7'h03, 6'h28, 3'h0));
        send_item(mk(K_BYTE_READ, 8'h00, 7'h00, 6'h00, 3'h0));
        send_item(mk(K_REFRESH, 8'h00, 7'h00, 6'h00, 3'h0));
        send_item(mk(K_CLEAR, 8'h00, 7'h00, 6'h00, 3'h0));
        send_item(mk(KIND_UNUSED_LO, 8'h00, 7'h00, 6'h00, 3'h0));
    endtask

    // well-formed drawing sequences with random content, plus some noise
    task automatic test_random_buffered(int unsigned target);
        int unsigned done_cnt;
        int unsigned sel;
        int unsigned n;
        logic [COL_W-1:0] col;
        done_cnt = 0;
        while (done_cnt < target)
        begin
            if ($urandom_range(9) == 0)
                calm = !calm;
            sel = $urandom_range(99);
            col = ($urandom_range(4) == 0) ? COL_W'($urandom_range(COLS - 1, COLS - 4))
                                           : COL_W'($urandom_range(COLS - 1));
            if (sel < 35 || (sel >= 60 && sel < 72))
            begin
                send_item(any_item(K_SET_PAGE));
                send_item(mk(K_SET_COL, BYTE_W'($urandom), col, ROW_W'($urandom),
                             PAGE_W'($urandom)));
                if (sel < 35)
                begin
                    n = $urandom_range(6, 1);
                    repeat (n) send_item(any_item(K_WRITE));
                end
                else
                begin
                    n = 1;
                    send_item(any_item(K_BYTE_READ));
                end
                done_cnt += 2 + n;
            end
            else if (sel < 60)
            begin
                send_item(any_item(pick_kind(K_PIX_SET, K_PIX_READ)));
                done_cnt++;
            end
            else if (sel < 82)
            begin
                n = $urandom_range(4, 1);
                repeat (n) send_item(any_item(K_REFRESH));
                done_cnt += n;
            end
            else if (sel < 85)
            begin
                send_item(any_item(K_CLEAR));
                done_cnt++;
            end
            else if (sel < 91)
                send_item(any_item(pick_kind(KIND_UNUSED_LO, KIND_UNUSED_HI)));
            else
            begin
                send_item(any_item(pick_kind(K_WRITE, K_CLEAR)));
                done_cnt++;
            end
        end
        calm = 1'b0;
    endtask

    task automatic test_random_direct(int unsigned target);
        int unsigned done_cnt;
        item_t it;
        done_cnt = 0;
        while (done_cnt < target)
        begin
            if ($urandom_range(9) == 0)
                calm = !calm;
            if ($urandom_range(9) == 0)
                it = any_item(pick_kind(KIND_UNUSED_LO, KIND_UNUSED_HI));
            else
                it = any_item(pick_kind(K_WRITE, K_CLEAR));
            send_item(it);
            if (it.kind < KIND_UNUSED_LO && it.kind != K_CLEAR)
                done_cnt++;
        end
        calm = 1'b0;
    endtask

    initial
    begin
        int unsigned stall_left;
        stall_left = 0;
        words_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left != 0)
            begin
                words_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                words_ch.ready <= 1'b1;
                if ($urandom_range(3) == 0)
                    stall_left = idle_len();
            end
        end
    end

    always @(posedge clk)
    begin
        word_t exp_w;
        if (rst_n && words_ch.valid && words_ch.ready)
        begin
            if (pending_words.size() == 0)
            begin
                $error("unexpected word: word_kind %0d value %0h frame_end %0b",
                       words_ch.word_kind, words_ch.value, words_ch.frame_end);
                errors++;
            end
            else
            begin
                exp_w = pending_words.pop_front();
                words_checked++;
                if (words_ch.word_kind !== exp_w.kind)
                begin
                    $error("word_kind: expected %0d, got %0d", exp_w.kind, words_ch.word_kind);
                    errors++;
                end
                if (words_ch.value !== exp_w.value)
                begin
                    $error("value: expected %0h, got %0h", exp_w.value, words_ch.value);
                    errors++;
                end
                if (words_ch.frame_end !== exp_w.frame_end)
                begin
                    $error("frame_end: expected %0b, got %0b", exp_w.frame_end,
                           words_ch.frame_end);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_page_framebuffer_pixel_engine: errors");
            $finish;
        end
    end

    initial
    begin
        foreach (pix_store[i])
            pix_store[i] = '0;
        pix_cursor    = 0;
        refresh_pos   = 0;
        buffered_on   = 1'b1;
        errors        = 0;
        items_sent    = 0;
        words_checked = 0;
        calm          = 1'b0;
        cycle_count   = 0;

        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_wdata          <= 1'b0;
        items_ch.valid     <= 1'b0;
        items_ch.kind      <= '0;
        items_ch.data_byte <= '0;
        items_ch.column    <= '0;
        items_ch.row       <= '0;
        items_ch.page      <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        set_mode(1'b1);
        test_buffered_directed();
        test_random_buffered(30);
        set_mode(1'b0);
        test_direct_directed();
        test_random_direct(15);
        set_mode(1'b1);
        test_random_buffered(30);

        items_ch.valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_words.size() != 0)
        begin
            $error("%0d expected words never arrived", pending_words.size());
            errors += pending_words.size();
        end

        $display("Ran %0d items through buffered drawing, refresh steps and direct mode,",
                 items_sent);
        $display("with %0d display and read words compared against the prediction.",
                 words_checked);
        if (errors == 0)
            $display("tb_page_framebuffer_pixel_engine: clean");
        else
            $display("tb_page_framebuffer_pixel_engine: errors");
        $finish;
    end

endmodule
